// ----- sv/ecr_pkg.sv -----
// ----------------------------------------------------------------------------
// ecr_pkg: echo ranger shared definitions
// Item types, widths, reset constants and lane control struct.
// ----------------------------------------------------------------------------
package ecr_pkg;

	localparam int CHANNELS_DEF  = 4;
	localparam int TIME_BITS_DEF = 32;

	localparam int OUT_CH      = 4;
	localparam int LEVEL_W     = 4;
	localparam int STAMP_W     = 32;
	localparam int DIST_W      = 34;
	localparam int SPEED_W     = 10;
	localparam int MASK_W      = 4;

	localparam logic [SPEED_W-1:0] SPEED_RESET = 10'd687;

	// floor(x / 5) = (x * DIV5_RECIP) >> DIV5_SHIFT for x < 2^30
	localparam int              RECIP_W    = 29;
	localparam int              DIV5_SHIFT = 31;
	localparam logic [RECIP_W-1:0] DIV5_RECIP = 29'h1999999A;

	typedef struct packed {
		logic [LEVEL_W-1:0] echo_levels;
		logic [STAMP_W-1:0] timestamp;
	} sample_t;

	typedef struct packed {
		logic [DIST_W-1:0] distance_ch0;
		logic [DIST_W-1:0] distance_ch1;
		logic [DIST_W-1:0] distance_ch2;
		logic [DIST_W-1:0] distance_ch3;
		logic [MASK_W-1:0] updated_mask;
	} result_t;

	typedef struct packed {
		logic acc;
		logic en2;
		logic en3;
	} lane_ctl_t;

endpackage

// ----- sv/ecr_lane.sv -----
// ----------------------------------------------------------------------------
// ecr_lane: one echo channel
// Edge detection, rise stamp, elapsed ticks, divide by 40, speed scaling.
// ----------------------------------------------------------------------------
module ecr_lane import ecr_pkg::*; #(
	parameter int TIME_BITS = TIME_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  lane_ctl_t            ctl,
	input  logic                 level,
	input  logic [TIME_BITS-1:0] stamp,
	input  logic [SPEED_W-1:0]   speed,
	output logic                 fall_s3,
	output logic [DIST_W-1:0]    dist_s3
);

	localparam int QW  = TIME_BITS - 3;
	localparam int PW  = QW + RECIP_W;
	localparam int US_W = TIME_BITS - 5;
	localparam int MW  = US_W + SPEED_W;

	logic                 prev_q;
	logic [TIME_BITS-1:0] rise_q;
	logic [TIME_BITS-1:0] ticks_s1;
	logic                 fall_s1;
	logic [US_W-1:0]      us_s2;
	logic                 fall_s2;
	logic [MW-1:0]        prod_s3;
	logic [PW-1:0]        div_prod;
	logic [MW-1:0]        mul_prod;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q <= 1'b0;
			rise_q <= '0;
		end else if (ctl.acc) begin
			prev_q <= level;
			if (level && !prev_q) begin
				rise_q <= stamp;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.acc) begin
			ticks_s1 <= stamp - rise_q;
			fall_s1  <= prev_q && !level;
		end
	end

	// ticks / 40 = (ticks >> 3) / 5
	assign div_prod = PW'(ticks_s1[TIME_BITS-1:3]) * PW'(DIV5_RECIP);

	always_ff @(posedge clk) begin
		if (ctl.en2) begin
			us_s2   <= div_prod[DIV5_SHIFT +: US_W];
			fall_s2 <= fall_s1;
		end
	end

	assign mul_prod = MW'(us_s2) * MW'(speed);

	always_ff @(posedge clk) begin
		if (ctl.en3) begin
			prod_s3 <= mul_prod;
			fall_s3 <= fall_s2;
		end
	end

	assign dist_s3 = DIST_W'(prod_s3 >> 3);

endmodule

// ----- sv/ecr_merge.sv -----
// ----------------------------------------------------------------------------
// ecr_merge: held distances and result register
// Takes lane results into the held set and forms the output item.
// ----------------------------------------------------------------------------
module ecr_merge import ecr_pkg::*; #(
	parameter int CHANNELS = CHANNELS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             load,
	input  logic [CHANNELS-1:0]              fall,
	input  logic [CHANNELS-1:0][DIST_W-1:0]  lane_dist,
	output result_t                          result
);

	logic [CHANNELS-1:0][DIST_W-1:0] held_q;
	logic [CHANNELS-1:0]             mask_q;
	logic [OUT_CH-1:0][DIST_W-1:0]   dist_out;
	logic [OUT_CH-1:0]               mask_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= '0;
			mask_q <= '0;
		end else if (load) begin
			mask_q <= fall;
			for (int i = 0; i < CHANNELS; i++) begin
				if (fall[i]) begin
					held_q[i] <= lane_dist[i];
				end
			end
		end
	end

	for (genvar i = 0; i < OUT_CH; i++) begin : g_out
		if (i < CHANNELS) begin : g_on
			assign dist_out[i] = held_q[i];
			assign mask_out[i] = mask_q[i];
		end else begin : g_off
			assign dist_out[i] = '0;
			assign mask_out[i] = 1'b0;
		end
	end

	assign result.distance_ch0 = dist_out[0];
	assign result.distance_ch1 = dist_out[1];
	assign result.distance_ch2 = dist_out[2];
	assign result.distance_ch3 = dist_out[3];
	assign result.updated_mask = mask_out;

endmodule

// ----- sv/four_channel_echo_ranger.sv -----
// ----------------------------------------------------------------------------
// four_channel_echo_ranger: multi-channel ultrasonic echo ranging
// Per-channel lanes time echo pulses; merge stage holds distances in um.
// ----------------------------------------------------------------------------
//  channel  | signals                               | direction
//  sample   | sample_valid, sample_stall, sample    | in
//  result   | result_valid, result_stall, result    | out
//  config   | cfg_we, cfg_wdata                     | in
//
//  One item per cycle while result_stall is low; stages are ticks, divide by 40,
//  speed multiply and result register. Each lane's two multipliers set the depth.
//  Reset clears edge state, rise stamps, held distances; speed to 687.
//  Stages advance when their successor is free, so a stalled result
//  still lets up to three further items enter.
// ----------------------------------------------------------------------------
module four_channel_echo_ranger import ecr_pkg::*; #(
	parameter int CHANNELS  = CHANNELS_DEF,
	parameter int TIME_BITS = TIME_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               sample_valid,
	output logic               sample_stall,
	input  sample_t            sample,
	output logic               result_valid,
	input  logic               result_stall,
	output result_t            result,
	input  logic               cfg_we,
	input  logic [SPEED_W-1:0] cfg_wdata
);

	logic                            v_s1, v_s2, v_s3, v_out_q;
	logic                            en1, en2, en3, en_out;
	logic [SPEED_W-1:0]              speed_q;
	lane_ctl_t                       ctl;
	logic [CHANNELS-1:0]             fall_s3;
	logic [CHANNELS-1:0][DIST_W-1:0] dist_s3;

	assign en_out = !v_out_q || !result_stall;
	assign en3    = !v_s3 || en_out;
	assign en2    = !v_s2 || en3;
	assign en1    = !v_s1 || en2;

	assign sample_stall = !en1;
	assign result_valid = v_out_q;

	assign ctl.acc = sample_valid && en1;
	assign ctl.en2 = en2;
	assign ctl.en3 = en3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
			v_out_q <= 1'b0;
		end else begin
			if (en1) begin
				v_s1 <= sample_valid;
			end
			if (en2) begin
				v_s2 <= v_s1;
			end
			if (en3) begin
				v_s3 <= v_s2;
			end
			if (en_out) begin
				v_out_q <= v_s3;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			speed_q <= SPEED_RESET;
		end else if (cfg_we) begin
			speed_q <= cfg_wdata;
		end
	end

	for (genvar i = 0; i < CHANNELS; i++) begin : g_lane
		logic lvl;
		if (i < LEVEL_W) begin : g_in
			assign lvl = sample.echo_levels[i];
		end else begin : g_none
			assign lvl = 1'b0;
		end

		ecr_lane #(
			.TIME_BITS(TIME_BITS)
		) u_lane (
			.clk    (clk),
			.arst_n (arst_n),
			.ctl    (ctl),
			.level  (lvl),
			.stamp  (sample.timestamp[TIME_BITS-1:0]),
			.speed  (speed_q),
			.fall_s3(fall_s3[i]),
			.dist_s3(dist_s3[i])
		);
	end

	ecr_merge #(
		.CHANNELS(CHANNELS)
	) u_merge (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (en_out && v_s3),
		.fall     (fall_s3),
		.lane_dist(dist_s3),
		.result   (result)
	);

endmodule

// ----- verif/echo_range_checker.sv -----
// ----------------------------------------------------------------------------
// echo_range_checker: scoreboard for the four channel echo ranger
// Watches the sample, result and config ports, keeps its own copy of the
// edge state, rise stamps, held distances and speed, predicts one result
// per accepted sample and compares results in order, field by field.
// ----------------------------------------------------------------------------
module echo_range_checker
	import ecr_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               sample_valid,
	input  logic               sample_stall,
	input  sample_t            sample,
	input  logic               result_valid,
	input  logic               result_stall,
	input  result_t            result,
	input  logic               cfg_we,
	input  logic [SPEED_W-1:0] cfg_wdata,
	output int                 mismatches,
	output int                 pending,
	output int                 ranges_checked,
	output int                 echoes_timed
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int TICKS_PER_US = 40;
	localparam int SHOWN_LIMIT  = 10;

	logic [SPEED_W-1:0] speed_x2;
	logic [LEVEL_W-1:0] last_levels;
	logic [STAMP_W-1:0] rise_stamp [OUT_CH];
	logic [DIST_W-1:0]  range_um [OUT_CH];
	result_t            expected_ranges [$];

	task automatic predict_ranges(input sample_t s, output result_t r);
		logic [STAMP_W-1:0] ticks;
		logic [63:0]        prod;
		logic [MASK_W-1:0]  fresh;
		fresh = '0;
		for (int ch = 0; ch < OUT_CH; ch++) begin
			if (s.echo_levels[ch] && !last_levels[ch]) begin
				rise_stamp[ch] = s.timestamp;
			end else if (!s.echo_levels[ch] && last_levels[ch]) begin
				ticks = s.timestamp - rise_stamp[ch];
				prod = 64'(ticks / TICKS_PER_US) * speed_x2;
				range_um[ch] = DIST_W'(prod / 8);
				fresh[ch] = 1'b1;
			end
		end
		last_levels = s.echo_levels;
		r.distance_ch0 = range_um[0];
		r.distance_ch1 = range_um[1];
		r.distance_ch2 = range_um[2];
		r.distance_ch3 = range_um[3];
		r.updated_mask = fresh;
	endtask

	task automatic flag_mismatch(input string what, input logic [DIST_W-1:0] want,
			input logic [DIST_W-1:0] got);
		mismatches++;
		if (mismatches <= SHOWN_LIMIT) begin
			$display("%0t: mismatch on %s, expected %0d, got %0d", $realtime, what, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		result_t want;
		if (!arst_n) begin
			speed_x2 = SPEED_RESET;
			last_levels = '0;
			for (int ch = 0; ch < OUT_CH; ch++) begin
				rise_stamp[ch] = '0;
				range_um[ch] = '0;
			end
			expected_ranges.delete();
			pending <= 0;
		end else begin
			if (cfg_we) begin
				speed_x2 = cfg_wdata;
			end
			if (sample_valid && !sample_stall) begin
				predict_ranges(sample, want);
				expected_ranges.push_back(want);
			end
			if (result_valid && !result_stall) begin
				if (expected_ranges.size() == 0) begin
					flag_mismatch("result with no sample outstanding (mask)", '0,
						DIST_W'(result.updated_mask));
				end else begin
					want = expected_ranges.pop_front();
					if (result.distance_ch0 !== want.distance_ch0)
						flag_mismatch("distance_ch0", want.distance_ch0, result.distance_ch0);
					if (result.distance_ch1 !== want.distance_ch1)
						flag_mismatch("distance_ch1", want.distance_ch1, result.distance_ch1);
					if (result.distance_ch2 !== want.distance_ch2)
						flag_mismatch("distance_ch2", want.distance_ch2, result.distance_ch2);
					if (result.distance_ch3 !== want.distance_ch3)
						flag_mismatch("distance_ch3", want.distance_ch3, result.distance_ch3);
					if (result.updated_mask !== want.updated_mask)
						flag_mismatch("updated_mask", DIST_W'(want.updated_mask),
							DIST_W'(result.updated_mask));
					ranges_checked++;
					echoes_timed += $countones(want.updated_mask);
				end
			end
			pending <= expected_ranges.size();
		end
	end

endmodule

// ----- verif/four_channel_echo_ranger_test.sv -----
// ----------------------------------------------------------------------------
// four_channel_echo_ranger_test: top level testbench for the echo ranger
// Drives echo samples with random gaps and result stalls, including a long
// output hold-off, walks the speed register through several settings and
// leaves prediction and comparison to the checker beside the block.
// ----------------------------------------------------------------------------
module four_channel_echo_ranger_test;
	timeunit 1ns;
	timeprecision 1ps;
	import ecr_pkg::*;

	localparam int HOLD_CYCLES     = 120;
	localparam int DRAIN_CYCLES    = 8;
	localparam int CYCLE_LIMIT     = 200000;
	localparam int PHASES          = 6;
	localparam int ITEMS_PER_PHASE = 75;

	logic               clk;
	logic               arst_n;
	logic               sample_valid;
	logic               sample_stall;
	sample_t            sample_item;
	logic               result_valid;
	logic               result_stall;
	result_t            result_item;
	logic               cfg_we;
	logic [SPEED_W-1:0] cfg_wdata;

	int mismatches;
	int pending;
	int ranges_checked;
	int echoes_timed;
	int cycle_count;

	bit                 no_gaps;
	bit                 hold_req;
	logic [STAMP_W-1:0] now_ts;
	logic [LEVEL_W-1:0] now_levels;

	four_channel_echo_ranger DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.sample_valid(sample_valid),
		.sample_stall(sample_stall),
		.sample      (sample_item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result      (result_item),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata)
	);

	echo_range_checker range_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.sample_valid  (sample_valid),
		.sample_stall  (sample_stall),
		.sample        (sample_item),
		.result_valid  (result_valid),
		.result_stall  (result_stall),
		.result        (result_item),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.mismatches    (mismatches),
		.pending       (pending),
		.ranges_checked(ranges_checked),
		.echoes_timed  (echoes_timed)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	task automatic send_sample(input logic [LEVEL_W-1:0] levels,
			input logic [STAMP_W-1:0] ts);
		sample_t s;
		int      gap;
		s.echo_levels = levels;
		s.timestamp = ts;
		gap = no_gaps ? 0 : $urandom_range(0, 4);
		if (gap > 0) begin
			sample_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		sample_valid <= 1'b1;
		sample_item <= s;
		do @(posedge clk); while (sample_stall);
	endtask

	task automatic send_random_sample();
		case ($urandom_range(0, 19))
			0: now_ts = $urandom();
			1, 2: now_ts = now_ts + $urandom_range(0, 39);
			3: now_ts = now_ts + $urandom_range(32'h1000_0000, 32'hFFFF_FFFF);
			default: now_ts = now_ts + $urandom_range(40, 400000);
		endcase
		// mostly clean pulse trains, some arbitrary level noise
		if ($urandom_range(0, 9) == 0)
			now_levels = LEVEL_W'($urandom_range(0, 15));
		else
			now_levels = now_levels ^ LEVEL_W'($urandom_range(0, 15) & $urandom_range(0, 15));
		send_sample(now_levels, now_ts);
	endtask

	task automatic wait_idle();
		sample_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_speed(input logic [SPEED_W-1:0] speed);
		wait_idle();
		cfg_we <= 1'b1;
		cfg_wdata <= speed;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin : result_sink
		int rx_wait;
		rx_wait = 0;
		result_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (result_valid && !result_stall)
				rx_wait = no_gaps ? 0 : $urandom_range(0, 4);
			if (hold_req) begin
				hold_req = 1'b0;
				rx_wait = HOLD_CYCLES;
			end
			if (rx_wait > 0) begin
				result_stall <= 1'b1;
				rx_wait--;
			end else begin
				result_stall <= 1'b0;
			end
		end
	end

	initial begin : watchdog
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Timeout after %0d cycles, %0d results outstanding", cycle_count, pending);
		$display("Test completed with failures");
		$finish;
	end

	initial begin : stimulus
		logic [SPEED_W-1:0] speed;
		arst_n <= 1'b0;
		sample_valid <= 1'b0;
		sample_item <= '0;
		cfg_we <= 1'b0;
		cfg_wdata <= '0;
		no_gaps = 1'b0;
		hold_req = 1'b0;
		now_ts = '0;
		now_levels = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset speed: plain pulse, wrap, longest and sub-microsecond pulses
		send_sample(4'h0, 32'd0);
		send_sample(4'hF, 32'd100);
		send_sample(4'h0, 32'd40100);
		send_sample(4'h1, 32'hFFFF_FF00);
		send_sample(4'h0, 32'h0000_0100);
		send_sample(4'h2, 32'd5);
		send_sample(4'h0, 32'd4);
		send_sample(4'h4, 32'd1000);
		send_sample(4'h0, 32'd1039);
		send_sample(4'h8, 32'hFFFF_FFFF);
		send_sample(4'h0, 32'hFFFF_FFFF);
		send_sample(4'h5, 32'd2000);
		send_sample(4'hA, 32'd2080);
		send_sample(4'h0, 32'd9000);

		// speed extremes
		write_speed(10'd1023);
		send_sample(4'hF, 32'd10);
		send_sample(4'h0, 32'd9);
		write_speed(10'd0);
		send_sample(4'hF, 32'd0);
		send_sample(4'h0, 32'h8000_0000);
		write_speed(10'd600);
		send_sample(4'hF, 32'd0);
		send_sample(4'h0, 32'd4000000);
		write_speed(10'd760);
		send_sample(4'hF, 32'd0);
		send_sample(4'h0, 32'd4000000);

		for (int ph = 0; ph < PHASES; ph++) begin
			case (ph)
				0: speed = SPEED_RESET;
				1: speed = 10'd600;
				2: speed = 10'd760;
				3: speed = SPEED_W'($urandom_range(600, 760));
				4: speed = SPEED_W'($urandom_range(0, 1023));
				default: speed = 10'd1023;
			endcase
			write_speed(speed);
			no_gaps = (ph == 2);
			if (ph == 4)
				hold_req = 1'b1;
			repeat (ITEMS_PER_PHASE) send_random_sample();
		end

		no_gaps = 1'b0;
		wait_idle();
		$display("Checked %0d results and %0d timed echoes over seven speed settings,",
			ranges_checked, echoes_timed);
		$display("with stamp wrap, result hold-off and input backpressure; %0d mismatches.",
			mismatches);
		if (mismatches == 0 && pending == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

// ----- four_channel_echo_ranger.f -----
sv/ecr_pkg.sv
sv/ecr_lane.sv
sv/ecr_merge.sv
sv/four_channel_echo_ranger.sv
verif/echo_range_checker.sv
verif/four_channel_echo_ranger_test.sv
